FILE: rtl/kst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_BITS    = 32;
  localparam int INDEX_BITS  = 32;

  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int FILL_BITS   = ADDR_BITS + 1;

  localparam int KEY_W       = 32;
  localparam int OUT_IDX_W   = 32;
  localparam int CAP_W       = 11;
  localparam int ROW_W       = 16;
  localparam int CNT_W       = 17;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
  localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(65535);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(65536);

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [ADDR_BITS-1:0] idx;
  } kst_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } kst_state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic clear_step;
    logic advance;
    logic check;
    logic commit;
  } kst_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic clear_last;
    logic match;
    logic empty;
    logic exhausted;
    logic out_free;
  } kst_status_t;

  function automatic logic [ADDR_BITS-1:0] key_hash(input logic [KEY_BITS-1:0] k);
    logic [ADDR_BITS-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_BITS; i += ADDR_BITS) begin
      h = h ^ ADDR_BITS'(k >> i);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/kst_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kst_in_if;
  import kst_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             last_of_batch;
  modport source (output valid, output key, output last_of_batch, input ready);
  modport sink (input valid, input key, input last_of_batch, output ready);
endinterface

interface kst_out_if;
  import kst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] assigned_index;
  logic                 hit;
  logic [ROW_W-1:0]     batch_row;
  logic [CNT_W-1:0]     hits_so_far;
  logic [CNT_W-1:0]     misses_so_far;
  logic                 overflow_flag;
  logic                 batch_end;
  modport source (output valid, output assigned_index, output hit, output batch_row,
                  output hits_so_far, output misses_so_far, output overflow_flag,
                  output batch_end, input ready);
  modport sink (input valid, input assigned_index, input hit, input batch_row,
                input hits_so_far, input misses_so_far, input overflow_flag,
                input batch_end, output ready);
endinterface

interface kst_cfg_if;
  import kst_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_limit;
  modport source (output valid, output capacity_limit, input ready);
  modport sink (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

FILE: rtl/kst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/kst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kst_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kst_pkg::kst_status_t st,
  output kst_pkg::kst_cmd_t         cmd
);
  import kst_pkg::*;

  kst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (st.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (st.in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (st.match || st.empty || st.exhausted) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = st.in_valid;
      end
      ST_CHECK: begin
        if (st.match || st.empty || st.exhausted) begin
          cmd.check = 1'b1;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.commit = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/kst_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module kst_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire kst_pkg::kst_cmd_t cmd,
  output kst_pkg::kst_status_t   st,
  kst_in_if.sink                 in_ch,
  kst_out_if.source              out_ch,
  kst_cfg_if.sink                cfg_ch
);
  import kst_pkg::*;

  logic [CAP_W-1:0]      cap_r;
  logic [KEY_BITS-1:0]   key_r;
  logic                  last_r;
  logic [ADDR_BITS-1:0]  probe_addr_r;
  logic [ADDR_BITS-1:0]  probe_cnt_r;
  logic [ADDR_BITS-1:0]  clr_addr_r;
  logic                  hit_r;
  logic [ADDR_BITS-1:0]  hit_idx_r;

  logic [INDEX_BITS-1:0] next_index_r, next_index_nxt;
  logic [FILL_BITS-1:0]  stored_count_r;
  logic [ROW_W-1:0]      row_r;
  logic [CNT_W-1:0]      hits_r, hits_nxt;
  logic [CNT_W-1:0]      misses_r, misses_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] result;

  logic                  full;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr;
  kst_entry_t            ram_wdata;
  kst_entry_t            rd;

  kst_ram #(
    .WIDTH($bits(kst_entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(probe_addr_r),
    .rdata(rd)
  );

  assign full = (stored_count_r == FILL_BITS'(TABLE_DEPTH));

  assign st.in_valid   = in_ch.valid;
  assign st.clear_last = (clr_addr_r == '1);
  assign st.match      = rd.valid && (rd.key == key_r);
  assign st.empty      = !rd.valid;
  assign st.exhausted  = (probe_cnt_r == '1);
  assign st.out_free   = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    ram_we    = cmd.clear_step || (cmd.commit && !hit_r && !full);
    ram_waddr = cmd.clear_step ? clr_addr_r : probe_addr_r;
    ram_wdata = '0;
    if (!cmd.clear_step) begin
      ram_wdata.valid = 1'b1;
      ram_wdata.key   = key_r;
      ram_wdata.idx   = stored_count_r[ADDR_BITS-1:0];
    end
  end

  always_comb begin
    next_index_nxt = next_index_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    if (hit_r) begin
      result = INDEX_BITS'(hit_idx_r);
      if (hits_r < CNT_MAX) hits_nxt = hits_r + CNT_W'(1);
    end else begin
      result = next_index_r;
      if (next_index_r != '1) next_index_nxt = next_index_r + INDEX_BITS'(1);
      if (misses_r < CNT_MAX) misses_nxt = misses_r + CNT_W'(1);
    end
    ovf_nxt = ovf_r || (next_index_nxt > INDEX_BITS'(cap_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.capacity_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_addr_r <= clr_addr_r + ADDR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r        <= in_ch.key[KEY_BITS-1:0];
      last_r       <= in_ch.last_of_batch;
      probe_addr_r <= key_hash(in_ch.key[KEY_BITS-1:0]);
      probe_cnt_r  <= '0;
    end else if (cmd.advance) begin
      probe_addr_r <= probe_addr_r + ADDR_BITS'(1);
      probe_cnt_r  <= probe_cnt_r + ADDR_BITS'(1);
    end
    if (cmd.check) begin
      hit_r     <= st.match;
      hit_idx_r <= rd.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r   <= '0;
      stored_count_r <= '0;
      row_r          <= '0;
      hits_r         <= '0;
      misses_r       <= '0;
      ovf_r          <= 1'b0;
    end else if (cmd.commit) begin
      next_index_r <= next_index_nxt;
      ovf_r        <= ovf_nxt;
      if (!hit_r && !full) stored_count_r <= stored_count_r + FILL_BITS'(1);
      if (last_r) begin
        row_r    <= '0;
        hits_r   <= '0;
        misses_r <= '0;
      end else begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
        if (row_r < ROW_MAX) row_r <= row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ch.assigned_index <= OUT_IDX_W'(result);
      out_ch.hit            <= hit_r;
      out_ch.batch_row      <= row_r;
      out_ch.hits_so_far    <= hits_nxt;
      out_ch.misses_so_far  <= misses_nxt;
      out_ch.overflow_flag  <= ovf_nxt;
      out_ch.batch_end      <= last_r;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/key_to_sequential_id_table.sv
// Key to sequential id table.
// Keys arrive as beats on in_ch (key, last_of_batch); each key yields one
// result beat on out_ch with its index, a hit flag, the row within the batch,
// running hit and miss counts, the sticky overflow flag and a batch end copy.
// The capacity limit is written through cfg_ch, which is always ready.
// Keys live in a hashed table with linear probing, held in one single-port
// read, single-port write RAM with a registered read. Each probe passes
// through a read state and then a compare state; a key ends its probing on a
// match, an empty entry, or after 1024 probes when the table is full and the
// key is new, and its result then moves to the output register once that is
// free. One key is in flight at a time; the next key can be accepted in the
// cycle after the previous result has moved to the output register, so no
// key is taken while the previous one is still being looked up.
// After reset a clearing pass writes each of the 1024 table entries as empty;
// in_ch.ready stays low during it. If the receiver stalls, the result waits
// in the output register, one more key is processed, and its result waits
// inside until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module key_to_sequential_id_table (
  input  wire logic clk,
  input  wire logic rst_n,
  kst_in_if.sink    in_ch,
  kst_out_if.source out_ch,
  kst_cfg_if.sink   cfg_ch
);
  import kst_pkg::*;

  kst_cmd_t    cmd;
  kst_status_t st;

  kst_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .cmd  (cmd)
  );

  kst_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .st    (st),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kst_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_NS    = 20_000_000;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] index;
    logic                 hit;
    logic [ROW_W-1:0]     row;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
    logic                 overflow;
    logic                 batch_end;
  } id_result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
    logic             typed;
    id_result_t       want;
  } dir_row_t;

  typedef enum {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FREE} phase_t;

  logic clk;
  logic rst_n;

  kst_in_if  in_ch();
  kst_out_if out_ch();
  kst_cfg_if cfg_ch();

  key_to_sequential_id_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Table of known contents and running batch totals.
  logic [OUT_IDX_W-1:0] id_of_key [bit [KEY_W-1:0]];
  logic [KEY_W-1:0]     stored_keys [$];
  logic [KEY_W-1:0]     spilled_keys [$];
  logic [OUT_IDX_W-1:0] next_id = '0;
  int                   stored_cnt = 0;
  logic [ROW_W-1:0]     batch_row = '0;
  logic [CNT_W-1:0]     batch_hits = '0;
  logic [CNT_W-1:0]     batch_misses = '0;
  logic                 overflow_seen = 1'b0;
  logic [CAP_W-1:0]     cap_limit = CAP_RESET;

  id_result_t expected_ids [$];
  int         bad_beats = 0;
  int         beat_no = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         slow_left = 60;
  logic       rx_hold = 1'b0;
  phase_t     phase = PH_SLOW_SINK;

  dir_row_t dir_rows [21] = '{
    '{32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b0, 16'd0, 17'd0, 17'd1, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, '{32'd1, 1'b0, 16'd1, 17'd0, 17'd2, 1'b0, 1'b0}},
    '{32'h0000_0000, 1'b0, 1'b1, '{32'd0, 1'b1, 16'd2, 17'd1, 17'd2, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd1, 1'b1, 16'd3, 17'd2, 17'd2, 1'b0, 1'b1}},
    '{32'h0000_0000, 1'b1, 1'b1, '{32'd0, 1'b1, 16'd0, 17'd1, 17'd0, 1'b0, 1'b1}},
    '{32'h0000_0001, 1'b0, 1'b1, '{32'd2, 1'b0, 16'd0, 17'd0, 17'd1, 1'b0, 1'b0}},
    '{32'h0000_0400, 1'b0, 1'b1, '{32'd3, 1'b0, 16'd1, 17'd0, 17'd2, 1'b0, 1'b0}},
    '{32'h0010_0000, 1'b0, 1'b1, '{32'd4, 1'b0, 16'd2, 17'd0, 17'd3, 1'b0, 1'b0}},
    '{32'h4000_0000, 1'b0, 1'b1, '{32'd5, 1'b0, 16'd3, 17'd0, 17'd4, 1'b0, 1'b0}},
    '{32'h4000_0000, 1'b0, 1'b1, '{32'd5, 1'b1, 16'd4, 17'd1, 17'd4, 1'b0, 1'b0}},
    '{32'h0000_0400, 1'b0, 1'b1, '{32'd3, 1'b1, 16'd5, 17'd2, 17'd4, 1'b0, 1'b0}},
    '{32'h0000_0001, 1'b1, 1'b1, '{32'd2, 1'b1, 16'd6, 17'd3, 17'd4, 1'b0, 1'b1}},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'h0000_0401, 1'b0, 1'b0, '0},
    '{32'h0000_0401, 1'b1, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b1, 1'b0, '0}
  };

  function automatic id_result_t lookup_or_insert(input logic [KEY_W-1:0] key,
                                                  input logic last);
    id_result_t r;
    r = '0;
    if (id_of_key.exists(key)) begin
      r.index = id_of_key[key];
      r.hit   = 1'b1;
      if (batch_hits < CNT_MAX) batch_hits++;
    end else begin
      r.index = next_id;
      if (next_id != '1) next_id++;
      if (stored_cnt < TABLE_DEPTH) begin
        id_of_key[key] = r.index;
        stored_keys = {stored_keys, key};
        stored_cnt++;
      end else begin
        spilled_keys = {spilled_keys, key};
      end
      if (batch_misses < CNT_MAX) batch_misses++;
    end
    if (next_id > cap_limit) overflow_seen = 1'b1;
    r.row       = batch_row;
    r.hits      = batch_hits;
    r.misses    = batch_misses;
    r.overflow  = overflow_seen;
    r.batch_end = last;
    if (last) begin
      batch_row    = '0;
      batch_hits   = '0;
      batch_misses = '0;
    end else if (batch_row < ROW_MAX) begin
      batch_row++;
    end
    return r;
  endfunction

  task automatic offer_key(input logic [KEY_W-1:0] key, input logic last,
                           input logic typed, input id_result_t want);
    id_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.key           <= key;
    in_ch.last_of_batch <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = lookup_or_insert(key, last);
    if (typed) predicted = want;
    expected_ids = {expected_ids, predicted};
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_ids.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.capacity_limit <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cap_limit = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Once the table is full, every new or spilled key walks the whole table, so those
  // are rationed and the rest of the traffic repeats stored keys.
  task automatic run_random(input int count);
    logic [KEY_W-1:0] k;
    int               roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (stored_cnt < TABLE_DEPTH) begin
        k = (roll < 75) ? $urandom() : stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (slow_left > 0 && roll < 15) begin
        k = $urandom();
        slow_left--;
      end else if (slow_left > 0 && roll < 25 && spilled_keys.size() != 0) begin
        k = spilled_keys[$urandom_range(spilled_keys.size() - 1)];
        slow_left--;
      end else begin
        k = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end
      offer_key(k, $urandom_range(11) == 0, 1'b0, '0);
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.key             = '0;
    in_ch.last_of_batch   = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.capacity_limit = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 27;
    rx_idle_pct <= 64;
    foreach (dir_rows[i]) begin
      offer_key(dir_rows[i].key, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    end
    drain_results();
    write_capacity(CAP_W'(2047));
    run_random(500);
    drain_results();

    tx_idle_pct = 64;
    rx_idle_pct <= 27;
    phase <= PH_SLOW_SOURCE;
    write_capacity(CAP_W'(next_id + $urandom_range(100, 300)));
    run_random(500);
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    phase <= PH_FREE;
    write_capacity('0);
    run_random(530);
    drain_results();

    repeat (16) @(posedge clk);
    if (bad_beats == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    id_result_t got;
    id_result_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.assigned_index, out_ch.hit, out_ch.batch_row, out_ch.hits_so_far,
                out_ch.misses_so_far, out_ch.overflow_flag, out_ch.batch_end};
        if (expected_ids.size() == 0) begin
          if (bad_beats < 10) $display("Result beat %0d arrived with nothing pending.", beat_no);
          bad_beats++;
        end else begin
          want = expected_ids.pop_front();
          if (got !== want) begin
            if (bad_beats < 10) begin
              $display({"Result beat %0d: want idx=%0d hit=%0d row=%0d hits=%0d",
                        " miss=%0d ovf=%0d end=%0d"},
                       beat_no, want.index, want.hit, want.row, want.hits, want.misses,
                       want.overflow, want.batch_end);
              $display({"                 got  idx=%0d hit=%0d row=%0d hits=%0d",
                        " miss=%0d ovf=%0d end=%0d"},
                       got.index, got.hit, got.row, got.hits, got.misses,
                       got.overflow, got.batch_end);
            end
            bad_beats++;
          end
        end
        beat_no++;
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // A long stall on the result side while keys keep coming, so the input backs up.
  initial begin
    wait (phase == PH_FREE);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
